### hdl/imhq_pkg.sv
// Shared types and constants for the indexed min-heap queue.
package imhq_pkg;

    localparam int KEY_W  = 31;
    localparam int NODE_W = 6;
    localparam int NODE_COUNT = 64;
    localparam logic [KEY_W-1:0] KEY_MAX = 31'h7FFF_FFFF;

    localparam logic [1:0] CMD_INSERT   = 2'd0;
    localparam logic [1:0] CMD_DECREASE = 2'd1;
    localparam logic [1:0] CMD_POP      = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_REJECT = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;      // capture the request fields and the node map entry
        logic rd_map;     // read the mapped slot, or slot zero and the last slot for a pop
        logic rd_top;     // set the status and the popped fields
        logic do_insert;  // write new entry at the tail
        logic do_update;  // write lowered key at the mapped slot
        logic do_pop;     // move last entry to the root
        logic rd_up;      // read the parent of the current slot
        logic swap_up;    // swap current slot with its parent
        logic rd_down;    // read both children of the current slot
        logic swap_down;  // swap current slot with the chosen child
        logic finish;     // emit the result
    } imhq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] command;
        logic       present;
        logic       full;
        logic       empty;
        logic       lower;
        logic       at_root;
        logic       up_swap;
        logic       down_swap;
    } imhq_stat_t;

endpackage

### hdl/imhq_ctrl.sv
// Controller state machine for the indexed min-heap queue.
module imhq_ctrl
    import imhq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  imhq_stat_t stat,
    output imhq_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_MAP, S_DECIDE, S_UP_RD, S_UP_CHK, S_DN_RD, S_DN_CHK, S_DONE
    } state_t;

    state_t state_reg;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:   cmd.latch = start;
            S_MAP:    cmd.rd_map = 1'b1;
            S_DECIDE:
            begin
                cmd.rd_top = 1'b1;
                unique case (stat.command)
                    CMD_INSERT:   cmd.do_insert = stat.present ? 1'b0 : !stat.full;
                    CMD_DECREASE: cmd.do_update = stat.present && stat.lower;
                    CMD_POP:      cmd.do_pop = !stat.empty;
                    default:      cmd.do_pop = 1'b0;
                endcase
            end
            S_UP_RD:  cmd.rd_up = 1'b1;
            S_UP_CHK: cmd.swap_up = stat.up_swap;
            S_DN_RD:  cmd.rd_down = 1'b1;
            S_DN_CHK: cmd.swap_down = stat.down_swap;
            S_DONE:   cmd.finish = 1'b1;
            default:  cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:   if (start) state_reg <= S_MAP;
                S_MAP:    state_reg <= S_DECIDE;
                S_DECIDE:
                begin
                    if (cmd.do_insert || cmd.do_update)
                        state_reg <= S_UP_RD;
                    else if (cmd.do_pop)
                        state_reg <= S_DN_RD;
                    else
                        state_reg <= S_DONE;
                end
                S_UP_RD:  state_reg <= stat.at_root ? S_DONE : S_UP_CHK;
                S_UP_CHK: state_reg <= stat.up_swap ? S_UP_RD : S_DONE;
                S_DN_RD:  state_reg <= S_DN_CHK;
                S_DN_CHK: state_reg <= stat.down_swap ? S_DN_RD : S_DONE;
                S_DONE:   state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### hdl/imhq_dp.sv
// Datapath of the indexed min-heap queue: heap store, node map and result registers.
module imhq_dp
    import imhq_pkg::*;
#(
    parameter int HEAP_DEPTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  imhq_cmd_t         cmd,
    output imhq_stat_t        stat,
    input  logic [1:0]        command,
    input  logic [NODE_W-1:0] node,
    input  logic [15:0]       edge_weight,
    input  logic [30:0]       base_distance,
    output logic              done,
    output logic [1:0]        status,
    output logic [KEY_W-1:0]  popped_key,
    output logic [NODE_W-1:0] popped_node,
    output logic [$clog2(HEAP_DEPTH+1)-1:0] entries
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH+1);
    localparam int PW = AW + 2;
    localparam logic [CW-1:0] DEPTH_C = CW'(HEAP_DEPTH);

    // Heap slots hold key and node id together.
    logic [KEY_W+NODE_W-1:0] heap_mem [HEAP_DEPTH];
    logic [AW-1:0]           map_slot [NODE_COUNT];
    logic [NODE_COUNT-1:0]   present_reg;
    logic [CW-1:0]           count_reg;

    logic [1:0]        cmd_reg;
    logic [NODE_W-1:0] node_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [AW-1:0]     map_q_reg;
    logic [PW-1:0]     pos_reg;
    logic [KEY_W-1:0]  cur_key_reg;
    logic [NODE_W-1:0] cur_node_reg;
    logic [KEY_W+NODE_W-1:0] rd_a_reg, rd_b_reg;
    logic              done_reg;
    logic [1:0]        status_reg;
    logic [KEY_W-1:0]  pkey_reg;
    logic [NODE_W-1:0] pnode_reg;

    logic [31:0]      sum;
    logic [KEY_W-1:0] key_in;
    logic [PW-1:0]    parent, left, right, sel;
    logic [KEY_W-1:0] ka, kb;
    logic             lvalid, rvalid, take_l, take_r;

    assign sum    = 32'(edge_weight) + 32'(base_distance);
    assign key_in = sum[31] ? KEY_MAX : sum[KEY_W-1:0];

    assign parent = (pos_reg - PW'(1)) >> 1;
    assign left   = PW'({pos_reg, 1'b1});
    assign right  = PW'(left + PW'(1));
    assign ka     = rd_a_reg[KEY_W+NODE_W-1:NODE_W];
    assign kb     = rd_b_reg[KEY_W+NODE_W-1:NODE_W];
    assign lvalid = PW'(count_reg) > left;
    assign rvalid = PW'(count_reg) > right;
    assign take_l = lvalid && (ka < cur_key_reg);
    assign take_r = rvalid && (kb < (take_l ? ka : cur_key_reg));
    assign sel    = take_r ? right : left;

    always_comb
    begin
        stat.command   = cmd_reg;
        stat.present   = present_reg[node_reg];
        stat.full      = count_reg >= DEPTH_C;
        stat.empty     = count_reg == '0;
        stat.lower     = (CW'(map_q_reg) < count_reg) && (key_reg < ka);
        stat.at_root   = pos_reg == '0;
        stat.up_swap   = ka > cur_key_reg;
        stat.down_swap = take_l || take_r;
    end

    // Heap store: one write port, synchronous reads.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_map)
        begin
            if (cmd_reg == CMD_POP)
            begin
                rd_a_reg <= heap_mem[0];
                rd_b_reg <= heap_mem[AW'(count_reg - CW'(1))];
            end
            else
                rd_a_reg <= heap_mem[map_q_reg];
        end
        else if (cmd.rd_up)
            rd_a_reg <= heap_mem[parent[AW-1:0]];
        else if (cmd.rd_down)
        begin
            rd_a_reg <= heap_mem[left[AW-1:0]];
            rd_b_reg <= heap_mem[right[AW-1:0]];
        end

        if (cmd.do_insert)
            heap_mem[count_reg[AW-1:0]] <= {key_reg, node_reg};
        else if (cmd.do_update)
            heap_mem[map_q_reg] <= {key_reg, node_reg};
        else if (cmd.do_pop)
            heap_mem[0] <= rd_b_reg;
        else if (cmd.swap_up)
            heap_mem[pos_reg[AW-1:0]] <= rd_a_reg;
        else if (cmd.swap_down)
            heap_mem[pos_reg[AW-1:0]] <= take_r ? rd_b_reg : rd_a_reg;
        else if (cmd.rd_up || cmd.rd_down)
            heap_mem[pos_reg[AW-1:0]] <= {cur_key_reg, cur_node_reg};
    end

    // Node map, stored as flops; its entry for the request is registered on capture.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            map_q_reg <= map_slot[node];
        if (cmd.do_insert)
            map_slot[node_reg] <= count_reg[AW-1:0];
        else if (cmd.do_pop)
            map_slot[rd_b_reg[NODE_W-1:0]] <= '0;
        else if (cmd.swap_up)
        begin
            map_slot[rd_a_reg[NODE_W-1:0]] <= pos_reg[AW-1:0];
            map_slot[cur_node_reg]         <= parent[AW-1:0];
        end
        else if (cmd.swap_down)
        begin
            map_slot[take_r ? rd_b_reg[NODE_W-1:0] : rd_a_reg[NODE_W-1:0]]
                <= pos_reg[AW-1:0];
            map_slot[cur_node_reg] <= sel[AW-1:0];
        end
    end

    // The moving entry is written into its current slot on every read cycle of the walk.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_reg  <= command;
            node_reg <= node;
            key_reg  <= key_in;
        end
        if (cmd.rd_top)
        begin
            pkey_reg  <= cmd.do_pop ? ka : '0;
            pnode_reg <= cmd.do_pop ? rd_a_reg[NODE_W-1:0] : '0;
        end
        if (cmd.do_insert)
        begin
            pos_reg      <= PW'(count_reg);
            cur_key_reg  <= key_reg;
            cur_node_reg <= node_reg;
        end
        else if (cmd.do_update)
        begin
            pos_reg      <= PW'(map_q_reg);
            cur_key_reg  <= key_reg;
            cur_node_reg <= node_reg;
        end
        else if (cmd.do_pop)
        begin
            pos_reg      <= '0;
            cur_key_reg  <= rd_b_reg[KEY_W+NODE_W-1:NODE_W];
            cur_node_reg <= rd_b_reg[NODE_W-1:0];
        end
        else if (cmd.swap_up)
            pos_reg <= parent;
        else if (cmd.swap_down)
            pos_reg <= sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            status_reg  <= ST_OK;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.rd_top)
            begin
                unique case (cmd_reg)
                    CMD_INSERT:
                        if (stat.present)   status_reg <= ST_REJECT;
                        else if (stat.full) status_reg <= ST_FULL;
                        else                status_reg <= ST_OK;
                    CMD_DECREASE:
                        status_reg <= (stat.present && stat.lower) ? ST_OK : ST_REJECT;
                    CMD_POP:
                        status_reg <= stat.empty ? ST_EMPTY : ST_OK;
                    default: status_reg <= ST_OK;
                endcase
            end
            if (cmd.do_insert)
            begin
                present_reg[node_reg] <= 1'b1;
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.do_pop)
            begin
                present_reg[rd_a_reg[NODE_W-1:0]] <= 1'b0;
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign popped_key  = pkey_reg;
    assign popped_node = pnode_reg;
    assign entries     = count_reg;

endmodule

### hdl/indexed_min_heap_queue.sv
// Top level of the indexed min-heap queue with decrease-key.
// Each request passes through the map read and decide states, then any heap walk,
// in which each level moved takes a read state and a check state, then a done state
// whose result strobe is registered. A new request can be taken in the cycle of
// the result strobe, so the block holds one request at a time.
// Reset clears the count and the node presence bits at once; no clearing pass.
module indexed_min_heap_queue
    import imhq_pkg::*;
#(
    parameter int HEAP_DEPTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        command,
    input  logic [NODE_W-1:0] node,
    input  logic [15:0]       edge_weight,
    input  logic [30:0]       base_distance,
    output logic              done,
    output logic [1:0]        status,
    output logic [KEY_W-1:0]  popped_key,
    output logic [NODE_W-1:0] popped_node,
    output logic [$clog2(HEAP_DEPTH+1)-1:0] entries
);

    imhq_cmd_t  cmd;
    imhq_stat_t stat;

    // The controller sequences each request; the datapath holds the heap.
    // The heap slot store has one write port, so each swap of a walk takes a read state and a check state.
    imhq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    imhq_dp #(.HEAP_DEPTH(HEAP_DEPTH)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .command       (command),
        .node          (node),
        .edge_weight   (edge_weight),
        .base_distance (base_distance),
        .done          (done),
        .status        (status),
        .popped_key    (popped_key),
        .popped_node   (popped_node),
        .entries       (entries)
    );

endmodule
